// ----- rtl/seven_point_stencil_matvec_unit_macros.svh -----
// Assertion macros shared by the stencil unit RTL.
`ifndef SEVEN_POINT_STENCIL_MATVEC_UNIT_MACROS_SVH
`define SEVEN_POINT_STENCIL_MATVEC_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising edge, disabled in reset.
`define SPSM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge, disabled in reset.
`define SPSM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/spsm_pkg.sv -----
// Shared types, codes and helper functions of the stencil unit.
package spsm_pkg;

    localparam int MAX_X_DEFAULT = 16;
    localparam int MAX_Y_DEFAULT = 16;
    localparam int MAX_Z_DEFAULT = 16;

    // Width of a clamped grid dimension (holds up to 256).
    localparam int DIM_W = 9;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int ACC_W = 68;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic MODE_PRODUCT = 1'b0;
    localparam logic MODE_RESIDUAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 8'd3;

    // Stencil terms in the order they are issued.
    localparam logic [2:0] TERM_CENTER = 3'd0;
    localparam logic [2:0] TERM_XM = 3'd1;
    localparam logic [2:0] TERM_XP = 3'd2;
    localparam logic [2:0] TERM_YM = 3'd3;
    localparam logic [2:0] TERM_YP = 3'd4;
    localparam logic [2:0] TERM_ZM = 3'd5;
    localparam logic [2:0] TERM_ZP = 3'd6;

    // Coefficient lanes inside the 128-bit coefficient word.
    localparam logic [1:0] FLD_CENTER = 2'd0;
    localparam logic [1:0] FLD_RIGHT = 2'd1;
    localparam logic [1:0] FLD_UP = 2'd2;
    localparam logic [1:0] FLD_FRONT = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0] nx;
        logic [DIM_W-1:0] ny;
        logic [DIM_W-1:0] nz;
    } grid_t;

    typedef struct packed {
        logic [1:0] field;
        logic       en;
    } term_ctrl_t;

    typedef struct packed {
        logic       init;
        logic       load_rhs;
        logic       mul_en;
        logic [1:0] field;
        logic       term_en;
        logic       acc_en;
        logic       neg;
    } mac_ctrl_t;

    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic logic [31:0] cell_index(input logic [3:0] x, input logic [3:0] y,
                                               input logic [3:0] z, input int mx,
                                               input int my);
        return 32'(z) * 32'(mx) * 32'(my) + 32'(y) * 32'(mx) + 32'(x);
    endfunction

    function automatic logic [DIM_W-1:0] clamp_size(input logic [4:0] s, input int mx);
        if (s == 5'd0) begin
            return DIM_W'(1);
        end
        if (32'(s) > 32'(mx)) begin
            return DIM_W'(mx);
        end
        return DIM_W'(s);
    endfunction

endpackage

// ----- rtl/spsm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module spsm_ram
    import spsm_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = addr_width(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/spsm_term_gen.sv -----
// Address and enable generation for one stencil term of the current cell.
module spsm_term_gen
    import spsm_pkg::*;
#(
    parameter int MAX_X = MAX_X_DEFAULT,
    parameter int MAX_Y = MAX_Y_DEFAULT,
    parameter int MAX_Z = MAX_Z_DEFAULT,
    localparam int AW = addr_width(MAX_X * MAX_Y * MAX_Z)
) (
    input  logic [3:0]    cell_x,
    input  logic [3:0]    cell_y,
    input  logic [3:0]    cell_z,
    input  grid_t         grid,
    input  logic [2:0]    term,
    output logic [AW-1:0] coef_addr,
    output logic [AW-1:0] vec_addr,
    output term_ctrl_t    ctrl
);

    logic        xm_ok, xp_ok, ym_ok, yp_ok, zm_ok, zp_ok;
    logic [31:0] idx_c, idx_xm, idx_xp, idx_ym, idx_yp, idx_zm, idx_zp;

    // A neighbor on the low side exists unless the cell sits on the face;
    // one on the high side exists while it stays inside the configured grid.
    assign xm_ok = (cell_x != 4'd0);
    assign ym_ok = (cell_y != 4'd0);
    assign zm_ok = (cell_z != 4'd0);
    assign xp_ok = (DIM_W'(cell_x) + DIM_W'(1)) < grid.nx;
    assign yp_ok = (DIM_W'(cell_y) + DIM_W'(1)) < grid.ny;
    assign zp_ok = (DIM_W'(cell_z) + DIM_W'(1)) < grid.nz;

    assign idx_c  = cell_index(cell_x, cell_y, cell_z, MAX_X, MAX_Y);
    assign idx_xm = cell_index(cell_x - 4'd1, cell_y, cell_z, MAX_X, MAX_Y);
    assign idx_xp = cell_index(cell_x + 4'd1, cell_y, cell_z, MAX_X, MAX_Y);
    assign idx_ym = cell_index(cell_x, cell_y - 4'd1, cell_z, MAX_X, MAX_Y);
    assign idx_yp = cell_index(cell_x, cell_y + 4'd1, cell_z, MAX_X, MAX_Y);
    assign idx_zm = cell_index(cell_x, cell_y, cell_z - 4'd1, MAX_X, MAX_Y);
    assign idx_zp = cell_index(cell_x, cell_y, cell_z + 4'd1, MAX_X, MAX_Y);

    // Missing neighbors read the center cell so no address leaves the store.
    always_comb begin
        coef_addr = idx_c[AW-1:0];
        vec_addr = idx_c[AW-1:0];
        ctrl.field = FLD_CENTER;
        ctrl.en = 1'b0;
        unique case (term)
            TERM_CENTER: begin
                ctrl.en = 1'b1;
            end
            TERM_XM: begin
                ctrl.field = FLD_RIGHT;
                ctrl.en = xm_ok;
                if (xm_ok) begin
                    coef_addr = idx_xm[AW-1:0];
                    vec_addr = idx_xm[AW-1:0];
                end
            end
            TERM_XP: begin
                ctrl.field = FLD_RIGHT;
                ctrl.en = xp_ok;
                if (xp_ok) begin
                    vec_addr = idx_xp[AW-1:0];
                end
            end
            TERM_YM: begin
                ctrl.field = FLD_UP;
                ctrl.en = ym_ok;
                if (ym_ok) begin
                    coef_addr = idx_ym[AW-1:0];
                    vec_addr = idx_ym[AW-1:0];
                end
            end
            TERM_YP: begin
                ctrl.field = FLD_UP;
                ctrl.en = yp_ok;
                if (yp_ok) begin
                    vec_addr = idx_yp[AW-1:0];
                end
            end
            TERM_ZM: begin
                ctrl.field = FLD_FRONT;
                ctrl.en = zm_ok;
                if (zm_ok) begin
                    coef_addr = idx_zm[AW-1:0];
                    vec_addr = idx_zm[AW-1:0];
                end
            end
            TERM_ZP: begin
                ctrl.field = FLD_FRONT;
                ctrl.en = zp_ok;
                if (zp_ok) begin
                    vec_addr = idx_zp[AW-1:0];
                end
            end
            default: begin
                ctrl.en = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/spsm_mac.sv -----
// Shared multiplier and exact accumulator with rounding and saturation.
module spsm_mac
    import spsm_pkg::*;
(
    input  logic               aclk,
    input  mac_ctrl_t          ctrl,
    input  logic [127:0]       coef_word,
    input  logic signed [31:0] vec_data,
    input  logic signed [31:0] rhs_data,
    output logic signed [31:0] value,
    output logic               overflow
);

    logic signed [31:0]      coef_sel;
    logic signed [63:0]      prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0]        prod_ext;
    logic [ACC_W-1:0]        rounded;

    always_comb begin
        unique case (ctrl.field)
            FLD_CENTER: coef_sel = coef_word[31:0];
            FLD_RIGHT:  coef_sel = coef_word[63:32];
            FLD_UP:     coef_sel = coef_word[95:64];
            FLD_FRONT:  coef_sel = coef_word[127:96];
            default:    coef_sel = coef_word[31:0];
        endcase
    end

    // A term whose neighbor is missing enters as zero.
    always_comb begin
        prod_next = prod_reg;
        if (ctrl.mul_en) begin
            prod_next = ctrl.term_en ? (64'(coef_sel) * 64'(vec_data)) : 64'sd0;
        end
    end

    assign prod_ext = {{(ACC_W - 64){prod_reg[63]}}, prod_reg};

    // The sum is held in Q36.32 and never loses a bit before the final rounding.
    // The Q16.16 right-hand side enters shifted up by sixteen bits.
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.init) begin
            acc_next = ctrl.load_rhs ? {{(ACC_W - 48){rhs_data[31]}}, rhs_data, 16'd0}
                                     : '0;
        end else if (ctrl.acc_en) begin
            acc_next = ctrl.neg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg <= acc_next;
    end

    // Round to nearest with ties upward, then saturate to Q16.16.
    assign rounded = acc_reg + ACC_W'(32768);
    assign overflow = !((&rounded[ACC_W-1:47]) || !(|rounded[ACC_W-1:47]));
    assign value = overflow ? (rounded[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                            : rounded[47:16];

endmodule

// ----- rtl/seven_point_stencil_matvec_unit.sv -----
// Top level of the seven-point stencil matrix-vector unit.
//
// Input beats on s_* carry either a load or a compute request. A load writes
// the four coefficients, the vector entry and the right-hand side of one cell
// in the cycle it is accepted and yields no result beat; loads can stream at
// one beat per cycle. A compute beat takes the cell and its six neighbors and
// yields one result beat on m_*: the stencil sum, or the right-hand side minus
// that sum when mode is set. Neighbors outside the configured grid add zero,
// and a compute at a cell outside the grid returns zero without overflow.
// A compute beat passes through the accepting cycle, the run steps in which the
// single shared 32x32 multiplier handles one of the seven terms per cycle behind
// the registered memory reads, and a rounding step into the output register. The
// result beat and s_ready appear together as the result enters that register.
// An out-of-grid compute goes straight to the rounding step. The output
// register lets the block accept further beats while a result waits; a result
// that cannot leave because m_ready is low holds the block until the receiver
// takes the waiting beat. Configuration writes on cfg_* are always accepted and
// must only happen while the block is idle. Reset (aresetn low, synchronous)
// returns the control state, mode and grid sizes to their defaults; the cell
// stores are not cleared and a cell must be loaded before it is used.
module seven_point_stencil_matvec_unit
    import spsm_pkg::*;
#(
    parameter int MAX_X = MAX_X_DEFAULT,
    parameter int MAX_Y = MAX_Y_DEFAULT,
    parameter int MAX_Z = MAX_Z_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [3:0]            s_cell_x,
    input  logic [3:0]            s_cell_y,
    input  logic [3:0]            s_cell_z,
    input  logic signed [31:0]    s_coef_center,
    input  logic signed [31:0]    s_coef_right,
    input  logic signed [31:0]    s_coef_up,
    input  logic signed [31:0]    s_coef_front,
    input  logic signed [31:0]    s_vec_value,
    input  logic signed [31:0]    s_rhs_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_value,
    output logic                  m_overflow,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "seven_point_stencil_matvec_unit_macros.svh"

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW = addr_width(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Sequencer steps: reads issue in steps 0-6, products form in steps 1-7,
    // the accumulator starts in step 1 and takes terms in steps 2-8.
    localparam logic [3:0] STEP_ISSUE_LAST = 4'd6;
    localparam logic [3:0] STEP_MUL_FIRST = 4'd1;
    localparam logic [3:0] STEP_MUL_LAST = 4'd7;
    localparam logic [3:0] STEP_ACC_FIRST = 4'd2;
    localparam logic [3:0] STEP_LAST = 4'd8;

    logic [1:0]         state_reg, state_next;
    logic [3:0]         step_reg, step_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_value_reg, m_value_next;
    logic               m_overflow_reg, m_overflow_next;
    logic [3:0]         cell_x_reg, cell_y_reg, cell_z_reg;
    term_ctrl_t         term_q_reg;

    logic               mode_reg;
    logic [4:0]         size_x_reg, size_y_reg, size_z_reg;
    grid_t              grid;

    logic               s_accept;
    logic               in_grid;
    logic               load_in_range;
    logic               load_wr;
    logic [31:0]        load_idx;
    logic               issue_en;
    logic               out_load;
    mac_ctrl_t          mac_ctrl;

    logic [AW-1:0]      coef_addr, vec_addr;
    term_ctrl_t         term_ctrl;
    logic [127:0]       coef_word;
    logic [31:0]        vec_word, rhs_word;
    logic signed [31:0] mac_value;
    logic               mac_overflow;

    // Configuration registers; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PRODUCT;
            size_x_reg <= 5'd16;
            size_y_reg <= 5'd16;
            size_z_reg <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MODE:   mode_reg <= cfg_data[0];
                CFG_SIZE_X: size_x_reg <= cfg_data[4:0];
                CFG_SIZE_Y: size_y_reg <= cfg_data[4:0];
                CFG_SIZE_Z: size_z_reg <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign grid.nx = clamp_size(size_x_reg, MAX_X);
    assign grid.ny = clamp_size(size_y_reg, MAX_Y);
    assign grid.nz = clamp_size(size_z_reg, MAX_Z);

    // Input side. Loads go straight into the stores in the accepting cycle.
    assign s_ready = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    assign in_grid = (DIM_W'(s_cell_x) < grid.nx) && (DIM_W'(s_cell_y) < grid.ny) &&
                     (DIM_W'(s_cell_z) < grid.nz);
    assign load_in_range = (32'(s_cell_x) < 32'(MAX_X)) && (32'(s_cell_y) < 32'(MAX_Y)) &&
                           (32'(s_cell_z) < 32'(MAX_Z));
    assign load_wr = s_accept && (s_opcode == OP_LOAD) && load_in_range;
    assign load_idx = cell_index(s_cell_x, s_cell_y, s_cell_z, MAX_X, MAX_Y);

    assign issue_en = (state_reg == ST_RUN) && (step_reg <= STEP_ISSUE_LAST);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    spsm_term_gen #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y),
        .MAX_Z(MAX_Z)
    ) u_term_gen (
        .cell_x   (cell_x_reg),
        .cell_y   (cell_y_reg),
        .cell_z   (cell_z_reg),
        .grid     (grid),
        .term     (step_reg[2:0]),
        .coef_addr(coef_addr),
        .vec_addr (vec_addr),
        .ctrl     (term_ctrl)
    );

    spsm_ram #(
        .WIDTH(128),
        .DEPTH(DEPTH)
    ) u_coef_ram (
        .aclk   (aclk),
        .wr_en  (load_wr),
        .wr_addr(load_idx[AW-1:0]),
        .wr_data({s_coef_front, s_coef_up, s_coef_right, s_coef_center}),
        .rd_en  (issue_en),
        .rd_addr(coef_addr),
        .rd_data(coef_word)
    );

    spsm_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_vec_ram (
        .aclk   (aclk),
        .wr_en  (load_wr),
        .wr_addr(load_idx[AW-1:0]),
        .wr_data(s_vec_value),
        .rd_en  (issue_en),
        .rd_addr(vec_addr),
        .rd_data(vec_word)
    );

    // The right-hand side is fetched once, at the center address, in step 0.
    spsm_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_rhs_ram (
        .aclk   (aclk),
        .wr_en  (load_wr),
        .wr_addr(load_idx[AW-1:0]),
        .wr_data(s_rhs_value),
        .rd_en  (issue_en && (step_reg == 4'd0)),
        .rd_addr(coef_addr),
        .rd_data(rhs_word)
    );

    spsm_mac u_mac (
        .aclk     (aclk),
        .ctrl     (mac_ctrl),
        .coef_word(coef_word),
        .vec_data (vec_word),
        .rhs_data (rhs_word),
        .value    (mac_value),
        .overflow (mac_overflow)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_overflow_next = m_overflow_reg;

        mac_ctrl.init = 1'b0;
        mac_ctrl.load_rhs = 1'b0;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.field = term_q_reg.field;
        mac_ctrl.term_en = term_q_reg.en;
        mac_ctrl.acc_en = 1'b0;
        mac_ctrl.neg = (mode_reg == MODE_RESIDUAL);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_opcode == OP_COMPUTE)) begin
                    step_next = 4'd0;
                    if (in_grid) begin
                        state_next = ST_RUN;
                    end else begin
                        // Outside the grid: the cleared accumulator gives zero.
                        mac_ctrl.init = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RUN: begin
                step_next = step_reg + 4'd1;
                mac_ctrl.mul_en = (step_reg >= STEP_MUL_FIRST) && (step_reg <= STEP_MUL_LAST);
                mac_ctrl.init = (step_reg == STEP_MUL_FIRST);
                mac_ctrl.load_rhs = (mode_reg == MODE_RESIDUAL);
                mac_ctrl.acc_en = (step_reg >= STEP_ACC_FIRST);
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_value_next = mac_value;
                    m_overflow_next = mac_overflow;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_overflow_reg <= m_overflow_next;
        if (s_accept) begin
            cell_x_reg <= s_cell_x;
            cell_y_reg <= s_cell_y;
            cell_z_reg <= s_cell_z;
        end
        if (issue_en) begin
            term_q_reg <= term_ctrl;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_overflow = m_overflow_reg;

    `SPSM_ASSERT_NOW(a_step_bound, aclk, aresetn,
        state_reg == ST_RUN, step_reg <= STEP_LAST,
        "sequencer step ran past the last term")

    `SPSM_ASSERT_NEXT(a_run_to_done, aclk, aresetn,
        state_reg == ST_RUN && step_reg == STEP_LAST, state_reg == ST_DONE,
        "sequencer did not finish after the last term")

    `SPSM_ASSERT_NEXT(a_load_no_result, aclk, aresetn,
        s_valid && s_ready && s_opcode == OP_LOAD && !m_valid_reg, !m_valid_reg,
        "a load beat produced a result")

    `SPSM_ASSERT_NEXT(a_done_delivers, aclk, aresetn,
        state_reg == ST_DONE && (!m_valid_reg || m_ready),
        state_reg == ST_IDLE && m_valid_reg,
        "finished result was not moved to the output register")

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the seven-point stencil matrix-vector unit.
`timescale 1ns / 1ps

module tb
    import spsm_pkg::*;
();

    // Grid edge of the store; the block is built with its default sizes.
    localparam int EDGE = 16;
    localparam int CELL_COUNT = EDGE * EDGE * EDGE;

    // Register indexes that map to nothing; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_FIRST = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LAST = 8'hFF;

    // Before a register write the block gets this many quiet cycles after the
    // last result, which also covers a load still being written.
    localparam int QUIET_CYCLES = 16;

    // Length of the long receiver hold-off used to fill the block up.
    localparam int HOLD_CYCLES = 300;

    // Generous run limit: roughly a thousand beats, each of which could wait
    // out a long sender gap, a full compute and a long receiver stall, plus
    // the quiet periods around every register update.
    localparam int CYCLE_LIMIT = 600000;

    // Saturation bounds of Q16.16 in the width of the exact accumulator.
    localparam logic signed [79:0] Q_MAX = 80'sd2147483647;
    localparam logic signed [79:0] Q_MIN = -80'sd2147483648;

    // Everything a load beat writes into one grid cell.
    typedef struct {
        logic signed [31:0] center;
        logic signed [31:0] right;
        logic signed [31:0] up;
        logic signed [31:0] front;
        logic signed [31:0] vec;
        logic signed [31:0] rhs;
    } cell_word_t;

    // One result beat as the block should present it.
    typedef struct {
        logic signed [31:0] value;
        logic               overflow;
    } stencil_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_opcode;
    logic [3:0]            s_cell_x;
    logic [3:0]            s_cell_y;
    logic [3:0]            s_cell_z;
    logic signed [31:0]    s_coef_center;
    logic signed [31:0]    s_coef_right;
    logic signed [31:0]    s_coef_up;
    logic signed [31:0]    s_coef_front;
    logic signed [31:0]    s_vec_value;
    logic signed [31:0]    s_rhs_value;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [31:0]    m_value;
    logic                  m_overflow;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the block: the cell contents, which cells were ever
    // loaded, and the register file as it was last written.
    cell_word_t grid_cells [CELL_COUNT];
    bit         cell_loaded [CELL_COUNT];
    logic       grid_mode;
    logic [4:0] grid_size_x;
    logic [4:0] grid_size_y;
    logic [4:0] grid_size_z;

    // Predicted result beats, oldest first.
    stencil_result_t results_due [$];

    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    int          hold_requests;
    int          holds_served;
    int          mismatches;
    int          results_seen;
    int          cycle_count;

    seven_point_stencil_matvec_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_cell_x      (s_cell_x),
        .s_cell_y      (s_cell_y),
        .s_cell_z      (s_cell_z),
        .s_coef_center (s_coef_center),
        .s_coef_right  (s_coef_right),
        .s_coef_up     (s_coef_up),
        .s_coef_front  (s_coef_front),
        .s_vec_value   (s_vec_value),
        .s_rhs_value   (s_rhs_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_overflow    (m_overflow),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A size register of zero means one cell; anything past the store edge
    // means the whole edge.
    function automatic int clamped_extent(input logic [4:0] s);
        if (s == 5'd0) begin
            return 1;
        end
        if (int'(s) > EDGE) begin
            return EDGE;
        end
        return int'(s);
    endfunction

    function automatic int cell_addr(input int x, input int y, input int z);
        return (z * EDGE + y) * EDGE + x;
    endfunction

    // Exact Q32.32 product of two Q16.16 values.
    function automatic logic signed [79:0] exact_product(input logic signed [31:0] a,
                                                         input logic signed [31:0] b);
        logic signed [79:0] wa;
        logic signed [79:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // The stencil sum (or the residual) at one cell, from the shadow state.
    // All seven products are summed exactly, the right-hand side enters at
    // Q32.32 weight, and the total is rounded once to Q16.16 with ties going
    // up before it saturates.
    function automatic stencil_result_t stencil_result_at(input int x, input int y,
                                                          input int z);
        stencil_result_t res;
        int nx;
        int ny;
        int nz;
        int c;
        int n;
        logic signed [79:0] sum;
        logic signed [79:0] rhs_wide;
        logic signed [79:0] acc;
        logic signed [79:0] rounded;
        nx = clamped_extent(grid_size_x);
        ny = clamped_extent(grid_size_y);
        nz = clamped_extent(grid_size_z);
        res.value = '0;
        res.overflow = 1'b0;
        // A cell outside the configured grid yields a plain zero.
        if (x >= nx || y >= ny || z >= nz) begin
            return res;
        end
        c = cell_addr(x, y, z);
        sum = exact_product(grid_cells[c].center, grid_cells[c].vec);
        // The minus-side neighbor contributes with its own coupling
        // coefficient, the plus-side neighbor with this cell's coefficient.
        if (x > 0) begin
            n = cell_addr(x - 1, y, z);
            sum += exact_product(grid_cells[n].right, grid_cells[n].vec);
        end
        if (x + 1 < nx) begin
            sum += exact_product(grid_cells[c].right, grid_cells[cell_addr(x + 1, y, z)].vec);
        end
        if (y > 0) begin
            n = cell_addr(x, y - 1, z);
            sum += exact_product(grid_cells[n].up, grid_cells[n].vec);
        end
        if (y + 1 < ny) begin
            sum += exact_product(grid_cells[c].up, grid_cells[cell_addr(x, y + 1, z)].vec);
        end
        if (z > 0) begin
            n = cell_addr(x, y, z - 1);
            sum += exact_product(grid_cells[n].front, grid_cells[n].vec);
        end
        if (z + 1 < nz) begin
            sum += exact_product(grid_cells[c].front, grid_cells[cell_addr(x, y, z + 1)].vec);
        end
        rhs_wide = grid_cells[c].rhs;
        acc = (grid_mode == MODE_RESIDUAL) ? ((rhs_wide <<< 16) - sum) : sum;
        rounded = (acc + 80'sd32768) >>> 16;
        if (rounded > Q_MAX) begin
            res.value = 32'sh7FFF_FFFF;
            res.overflow = 1'b1;
        end else if (rounded < Q_MIN) begin
            res.value = 32'sh8000_0000;
            res.overflow = 1'b1;
        end else begin
            res.value = rounded[31:0];
        end
        return res;
    endfunction

    // A compute beat may only go out if every cell it reads was loaded
    // before. Out-of-grid computes read nothing and are always allowed.
    function automatic bit computable(input int x, input int y, input int z);
        int nx;
        int ny;
        int nz;
        nx = clamped_extent(grid_size_x);
        ny = clamped_extent(grid_size_y);
        nz = clamped_extent(grid_size_z);
        if (x >= nx || y >= ny || z >= nz) begin
            return 1'b1;
        end
        if (!cell_loaded[cell_addr(x, y, z)]) begin
            return 1'b0;
        end
        if (x > 0 && !cell_loaded[cell_addr(x - 1, y, z)]) begin
            return 1'b0;
        end
        if (x + 1 < nx && !cell_loaded[cell_addr(x + 1, y, z)]) begin
            return 1'b0;
        end
        if (y > 0 && !cell_loaded[cell_addr(x, y - 1, z)]) begin
            return 1'b0;
        end
        if (y + 1 < ny && !cell_loaded[cell_addr(x, y + 1, z)]) begin
            return 1'b0;
        end
        if (z > 0 && !cell_loaded[cell_addr(x, y, z - 1)]) begin
            return 1'b0;
        end
        if (z + 1 < nz && !cell_loaded[cell_addr(x, y, z + 1)]) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly modest values so that sums stay in range and rounding matters,
    // with full-range words and the extremes mixed in to force saturation
    // and to toggle every bit.
    function automatic logic signed [31:0] random_q16();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    3: return 32'sh0000_0001;
                    default: return 32'shFFFF_FFFF;
                endcase
            end
            1, 2: return $urandom;
            default: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic cell_word_t random_cell_word();
        cell_word_t w;
        w.center = random_q16();
        w.right = random_q16();
        w.up = random_q16();
        w.front = random_q16();
        w.vec = random_q16();
        w.rhs = random_q16();
        return w;
    endfunction

    // Size settings lean toward small grids, but zero, one, the full edge
    // and values beyond it all come up; the upper data bits are sometimes
    // junk, since only the low five bits belong to the register.
    function automatic logic [31:0] random_size_setting();
        logic [31:0] d;
        case ($urandom_range(9))
            0: d = 32'd0;
            1: d = 32'($urandom_range(17, 31));
            2: d = 32'd16;
            3: d = 32'd1;
            default: d = 32'($urandom_range(2, 5));
        endcase
        if ($urandom_range(3) == 0) begin
            d[31:5] = 27'($urandom);
        end
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one beat on the input channel, with a random gap in front of
    // it, and holds it until the block takes it. The shadow state is
    // updated at the accepting edge, so predictions follow the exact order
    // in which the block sees the beats.
    task automatic send_beat(input logic op, input int x, input int y, input int z,
                             input cell_word_t w);
        int a;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_cell_x <= x[3:0];
        s_cell_y <= y[3:0];
        s_cell_z <= z[3:0];
        s_coef_center <= w.center;
        s_coef_right <= w.right;
        s_coef_up <= w.up;
        s_coef_front <= w.front;
        s_vec_value <= w.vec;
        s_rhs_value <= w.rhs;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        a = cell_addr(x, y, z);
        if (op == OP_LOAD) begin
            grid_cells[a] = w;
            cell_loaded[a] = 1'b1;
        end else begin
            results_due.push_back(stencil_result_at(x, y, z));
        end
    endtask

    // Stops offering beats, waits until every predicted result has been
    // taken, then lets the block settle before its registers are touched.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // One register write. The valid stays up so that writes can follow back
    // to back; release_csr_bus closes a group of writes.
    task automatic write_csr(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            CFG_MODE: grid_mode = data[0];
            CFG_SIZE_X: grid_size_x = data[4:0];
            CFG_SIZE_Y: grid_size_y = data[4:0];
            CFG_SIZE_Z: grid_size_z = data[4:0];
            default: ;
        endcase
    endtask

    task automatic release_csr_bus();
        cfg_valid <= 1'b0;
    endtask

    task automatic write_settings(input logic [31:0] mode_d, input logic [31:0] sx_d,
                                  input logic [31:0] sy_d, input logic [31:0] sz_d);
        write_csr(CFG_MODE, mode_d);
        write_csr(CFG_SIZE_X, sx_d);
        write_csr(CFG_SIZE_Y, sy_d);
        write_csr(CFG_SIZE_Z, sz_d);
        release_csr_bus();
    endtask

    // Picks a run of cells along one axis inside the grid: on small grids
    // often the whole axis, otherwise a short run at a random place.
    task automatic pick_span(input int ext, output int lo, output int len);
        if (ext <= 4 && $urandom_range(1) == 1) begin
            lo = 0;
            len = ext;
        end else begin
            lo = $urandom_range(ext - 1);
            len = $urandom_range(1, 4);
            if (lo + len > ext) begin
                len = ext - lo;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers are still at their reset values: product mode and the full
    // 16x16x16 grid. Two corners are computed, the origin with small values
    // and the far corner with extreme ones, after their neighbors are loaded.
    task automatic test_reset_defaults();
        send_beat(OP_LOAD, 1, 0, 0, cell_word_t'{32'sh0001_0000, 32'sh0000_8000, 32'sh0,
                  32'sh0, 32'sh0002_0000, 32'sh0});
        send_beat(OP_LOAD, 0, 1, 0, cell_word_t'{32'sh0001_0000, 32'sh0, 32'sh0000_4000,
                  32'sh0, 32'shFFFF_0000, 32'sh0});
        send_beat(OP_LOAD, 0, 0, 1, cell_word_t'{32'sh0, 32'sh0, 32'sh0, 32'sh0003_0000,
                  32'sh0000_0001, 32'sh0});
        send_beat(OP_LOAD, 0, 0, 0, cell_word_t'{32'sh0000_8000, 32'sh0001_0000,
                  32'shFFFE_0000, 32'sh0000_0001, 32'sh0001_8000, 32'sh1234_5678});
        send_beat(OP_COMPUTE, 0, 0, 0, random_cell_word());
        send_beat(OP_LOAD, 14, 15, 15, cell_word_t'{32'sh0, 32'sh7FFF_FFFF, 32'sh0,
                  32'sh0, 32'sh7FFF_FFFF, 32'sh0});
        send_beat(OP_LOAD, 15, 14, 15, cell_word_t'{32'sh0, 32'sh0, 32'sh8000_0000,
                  32'sh0, 32'sh7FFF_FFFF, 32'sh0});
        send_beat(OP_LOAD, 15, 15, 14, cell_word_t'{32'sh0, 32'sh0, 32'sh0,
                  32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0});
        send_beat(OP_LOAD, 15, 15, 15, cell_word_t'{32'shFFFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
        send_beat(OP_COMPUTE, 15, 15, 15, random_cell_word());
    endtask

    // A one-cell grid isolates the center term, so rounding and saturation
    // can be steered exactly. Size zero and a size with junk upper bits both
    // have to land on one cell. Halfway cases must round up on both signs,
    // and the residual must saturate in both directions. Computes outside
    // the grid must come back as zero without overflow.
    task automatic test_rounding_and_saturation();
        wait_until_idle();
        write_settings(32'(MODE_PRODUCT), 32'd0, 32'd1, 32'hFFFF_FFE1);
        send_beat(OP_LOAD, 0, 0, 0, cell_word_t'{32'sh0000_8000, 32'sh0, 32'sh0, 32'sh0,
                  32'sh0000_0001, 32'sh0});
        send_beat(OP_COMPUTE, 0, 0, 0, random_cell_word());
        send_beat(OP_LOAD, 0, 0, 0, cell_word_t'{32'sh0000_8000, 32'sh0, 32'sh0, 32'sh0,
                  32'shFFFF_FFFF, 32'sh0});
        send_beat(OP_COMPUTE, 0, 0, 0, random_cell_word());
        send_beat(OP_LOAD, 0, 0, 0, cell_word_t'{32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0,
                  32'sh7FFF_FFFF, 32'sh0});
        send_beat(OP_COMPUTE, 0, 0, 0, random_cell_word());
        wait_until_idle();
        write_settings(32'(MODE_RESIDUAL), 32'd0, 32'd1, 32'd1);
        send_beat(OP_LOAD, 0, 0, 0, cell_word_t'{32'shFFFF_0000, 32'sh0, 32'sh0, 32'sh0,
                  32'sh0001_0000, 32'sh7FFF_FFFF});
        send_beat(OP_COMPUTE, 0, 0, 0, random_cell_word());
        send_beat(OP_LOAD, 0, 0, 0, cell_word_t'{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0,
                  32'sh0001_0000, 32'sh8000_0000});
        send_beat(OP_COMPUTE, 0, 0, 0, random_cell_word());
        send_beat(OP_COMPUTE, 1, 0, 0, random_cell_word());
        send_beat(OP_COMPUTE, 0, 15, 0, random_cell_word());
    endtask

    // Writes to indexes that map to no register must leave mode and sizes
    // alone: the one-cell residual result has to stay the same.
    task automatic test_unmapped_registers();
        wait_until_idle();
        write_csr(CFG_UNMAPPED_FIRST, 32'h0000_0000);
        write_csr(CFG_UNMAPPED_LAST, 32'hFFFF_FFFF);
        release_csr_bus();
        send_beat(OP_COMPUTE, 0, 0, 0, random_cell_word());
    endtask

    // Sizes past the store edge clamp to the full edge, so the far corner
    // sees its three lower neighbors and nothing beyond.
    task automatic test_oversized_grid();
        wait_until_idle();
        write_settings(32'(MODE_PRODUCT), 32'd31, 32'd17, 32'd16);
        send_beat(OP_COMPUTE, 15, 15, 15, random_cell_word());
    endtask

    // The receiver holds off for a long stretch while computes keep coming,
    // so the output register fills and the block has to stall its input.
    // Afterwards the sender pauses until everything has drained, then a
    // second burst runs against a receiver that stalls now and then.
    task automatic test_output_backpressure();
        wait_until_idle();
        write_settings(32'(MODE_RESIDUAL), 32'd3, 32'd3, 32'd3);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        for (int z = 0; z < 3; z++) begin
            for (int y = 0; y < 3; y++) begin
                for (int x = 0; x < 3; x++) begin
                    send_beat(OP_LOAD, x, y, z, random_cell_word());
                end
            end
        end
        hold_requests++;
        repeat (16) begin
            send_beat(OP_COMPUTE, $urandom_range(2), $urandom_range(2), $urandom_range(2),
                      random_cell_word());
        end
        wait_until_idle();
        receiver_idle_pct = 50;
        repeat (8) begin
            send_beat(OP_COMPUTE, $urandom_range(2), $urandom_range(2), $urandom_range(2),
                      random_cell_word());
        end
    endtask

    // Random traffic in rounds. Each round may reprogram the registers, then
    // loads a small box of cells with random contents (with stray loads
    // anywhere in the store mixed in), then interleaves computes inside the
    // box, computes anywhere, and reloads of box cells. Computes only go out
    // where every cell they read has been loaded.
    task automatic test_random_traffic(input int beats, input int tx_idle, input int rx_idle);
        int issued;
        int nx;
        int ny;
        int nz;
        int ox;
        int oy;
        int oz;
        int lx;
        int ly;
        int lz;
        int x;
        int y;
        int z;
        sender_idle_pct = tx_idle;
        receiver_idle_pct = rx_idle;
        issued = 0;
        while (issued < beats) begin
            if ($urandom_range(2) == 0) begin
                wait_until_idle();
                write_settings(($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1)),
                               random_size_setting(), random_size_setting(),
                               random_size_setting());
            end
            nx = clamped_extent(grid_size_x);
            ny = clamped_extent(grid_size_y);
            nz = clamped_extent(grid_size_z);
            pick_span(nx, ox, lx);
            pick_span(ny, oy, ly);
            pick_span(nz, oz, lz);
            for (z = oz; z < oz + lz; z++) begin
                for (y = oy; y < oy + ly; y++) begin
                    for (x = ox; x < ox + lx; x++) begin
                        if (!cell_loaded[cell_addr(x, y, z)] || $urandom_range(3) != 0) begin
                            send_beat(OP_LOAD, x, y, z, random_cell_word());
                            issued++;
                        end
                        if ($urandom_range(9) == 0) begin
                            send_beat(OP_LOAD, $urandom_range(15), $urandom_range(15),
                                      $urandom_range(15), random_cell_word());
                            issued++;
                        end
                    end
                end
            end
            repeat ($urandom_range(4, 16)) begin
                x = ox + $urandom_range(lx - 1);
                y = oy + $urandom_range(ly - 1);
                z = oz + $urandom_range(lz - 1);
                case ($urandom_range(7))
                    0, 1: begin
                        send_beat(OP_LOAD, x, y, z, random_cell_word());
                        issued++;
                    end
                    2: begin
                        // Anywhere in the store; on small grids this is
                        // mostly a compute outside the grid.
                        x = $urandom_range(15);
                        y = $urandom_range(15);
                        z = $urandom_range(15);
                        if (computable(x, y, z)) begin
                            send_beat(OP_COMPUTE, x, y, z, random_cell_word());
                            issued++;
                        end
                    end
                    default: begin
                        if (computable(x, y, z)) begin
                            send_beat(OP_COMPUTE, x, y, z, random_cell_word());
                            issued++;
                        end
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver: random stalls at the current rate, plus a long hold-off
    // whenever a test asks for one, counted here cycle by cycle.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served++;
                for (int i = 0; i < HOLD_CYCLES; i++) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Every accepted result beat is matched against the oldest prediction.
    always @(posedge aclk) begin : check_results
        stencil_result_t due;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: result beat with nothing expected: value %h, overflow %b",
                         $time, m_value, m_overflow);
                mismatches++;
            end else begin
                due = results_due.pop_front();
                if (m_value !== due.value) begin
                    $display("%0t: result %0d value: expected %h, got %h",
                             $time, results_seen, due.value, m_value);
                    mismatches++;
                end
                if (m_overflow !== due.overflow) begin
                    $display("%0t: result %0d overflow: expected %b, got %b",
                             $time, results_seen, due.overflow, m_overflow);
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial begin
        mismatches = 0;
        results_seen = 0;
        cycle_count = 0;
        hold_requests = 0;
        holds_served = 0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        // Shadow registers start at their reset values.
        grid_mode = MODE_PRODUCT;
        grid_size_x = 5'd16;
        grid_size_y = 5'd16;
        grid_size_z = 5'd16;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_opcode <= OP_LOAD;
        s_cell_x <= '0;
        s_cell_y <= '0;
        s_cell_z <= '0;
        s_coef_center <= '0;
        s_coef_right <= '0;
        s_coef_up <= '0;
        s_coef_front <= '0;
        s_vec_value <= '0;
        s_rhs_value <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MODE;
        cfg_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_rounding_and_saturation();
        test_unmapped_registers();
        test_oversized_grid();
        test_output_backpressure();
        // Sender gaps light and receiver stalls heavy, then the reverse,
        // then both sides at full rate.
        test_random_traffic(310, 26, 87);
        test_random_traffic(310, 87, 26);
        test_random_traffic(310, 0, 0);

        wait_until_idle();
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/spsm_pkg.sv
rtl/spsm_ram.sv
rtl/spsm_term_gen.sv
rtl/spsm_mac.sv
rtl/seven_point_stencil_matvec_unit.sv
tb/sv/tb.sv
